// ----- sv/lsor_pkg.sv -----
// Shared types, constants and the sine table for the occupancy grid ray caster.
// Used by every module of the block; depends on nothing.
`default_nettype none

package lsor_pkg;

    // Grid and table geometry.
    localparam int GRID_SIDE        = 128;
    localparam int MAX_BEAMS        = 1024;
    localparam int SINE_TABLE_DEPTH = 1024;

    localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W     = $clog2(GRID_CELLS);
    localparam int GRID_W     = $clog2(GRID_SIDE);
    localparam int SINE_W     = $clog2(SINE_TABLE_DEPTH);

    // Fixed field widths.
    localparam int OPCODE_W   = 2;
    localparam int INDEX_W    = 10;
    localparam int RANGE_W    = 16;
    localparam int ANGLE_W    = 16;
    localparam int ROWCOL_W   = 7;
    localparam int VALUE_W    = 7;
    localparam int COUNT_W    = 9;
    localparam int TRIG_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Range times a Q1.15 sine gives Q10.23; the integer part starts at bit 23.
    localparam int PROD_W     = RANGE_W + 1 + TRIG_W;
    localparam int FRAC_SHIFT = 23;
    localparam int COORD_W    = ((GRID_W > 9) ? GRID_W : 9) + 2;

    localparam int CELL_STEP    = 256;
    localparam int QUARTER_TURN = 16384;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_FLOOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_CEILING = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP    = 3'd3;

    localparam logic [CFG_DATA_W-1:0] RANGE_FLOOR_RST   = 16'd0;
    localparam logic [CFG_DATA_W-1:0] RANGE_CEILING_RST = 16'd15360;
    localparam logic [CFG_DATA_W-1:0] ANGLE_START_RST   = 16'h8000;
    localparam logic [CFG_DATA_W-1:0] ANGLE_STEP_RST    = 16'd64;

    // Read results.
    localparam logic [VALUE_W-1:0] VAL_FREE    = 7'd0;
    localparam logic [VALUE_W-1:0] VAL_UNKNOWN = 7'd50;
    localparam logic [VALUE_W-1:0] VAL_OCC     = 7'd100;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_TRACE = 2'd1,
        OP_READ  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_TRACE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_kind_t;

    typedef enum logic [1:0] {
        CELL_FREE    = 2'd0,
        CELL_UNKNOWN = 2'd1,
        CELL_OCC     = 2'd2
    } cell_code_t;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        cmd_kind_t           kind;
        logic [RANGE_W-1:0]  rng;
        logic [SINE_W-1:0]   sin_idx;
        logic [SINE_W-1:0]   cos_idx;
        logic [ADDR_W-1:0]   cell_addr;
        logic                cell_in_grid;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    typedef logic signed [TRIG_W-1:0] sine_tab_t [SINE_TABLE_DEPTH];

    localparam longint unsigned Q30_ONE    = 64'd1073741824;
    localparam longint unsigned Q30_TWO_PI = 64'd6746518852;

    // Q1.15 sine of each table phase: a Q30 Taylor series to x^9 in the first
    // quadrant, rounded half up and saturated, mirrored into the others.
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t       tab;
        longint unsigned p;
        longint unsigned quad;
        longint unsigned u;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned f;
        longint unsigned s;
        longint unsigned q;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            p    = (longint'(k) * 65536) / SINE_TABLE_DEPTH;
            quad = (p >> 14) & 3;
            u    = p & 16383;
            if (quad == 1 || quad == 3) begin
                u = 16384 - u;
            end
            x  = (u * Q30_TWO_PI) >> 16;
            x2 = (x * x) >> 30;
            f  = Q30_ONE - x2 / 72;
            f  = Q30_ONE - ((x2 * f) >> 30) / 42;
            f  = Q30_ONE - ((x2 * f) >> 30) / 20;
            f  = Q30_ONE - ((x2 * f) >> 30) / 6;
            s  = (x * f) >> 30;
            q  = (s + 16384) >> 15;
            if (q > 32767) begin
                q = 32767;
            end
            tab[k] = (quad >= 2) ? -TRIG_W'(q) : TRIG_W'(q);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

// ----- sv/lsor_front.sv -----
// Front end: configuration registers and classification of incoming requests.
// Depends on lsor_pkg; feeds lsor_queue.
`default_nettype none

module lsor_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write_en,
    input  wire logic [lsor_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lsor_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [lsor_pkg::OPCODE_W-1:0]     opcode,
    input  wire logic [lsor_pkg::INDEX_W-1:0]      beam_index,
    input  wire logic [lsor_pkg::RANGE_W-1:0]      beam_range,
    input  wire logic [lsor_pkg::ROWCOL_W-1:0]     cell_row,
    input  wire logic [lsor_pkg::ROWCOL_W-1:0]     cell_col,
    output lsor_pkg::cmd_t                         cmd
);
    import lsor_pkg::*;

    logic [RANGE_W-1:0] range_floor_reg;
    logic [RANGE_W-1:0] range_ceiling_reg;
    logic [ANGLE_W-1:0] angle_start_reg;
    logic [ANGLE_W-1:0] angle_step_reg;

    logic [ANGLE_W-1:0] angle;
    logic [ANGLE_W-1:0] cos_angle;
    logic               beam_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_floor_reg   <= RANGE_FLOOR_RST;
            range_ceiling_reg <= RANGE_CEILING_RST;
            angle_start_reg   <= ANGLE_START_RST;
            angle_step_reg    <= ANGLE_STEP_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_RANGE_FLOOR:   range_floor_reg   <= cfg_data;
                REG_RANGE_CEILING: range_ceiling_reg <= cfg_data;
                REG_ANGLE_START:   angle_start_reg   <= cfg_data;
                REG_ANGLE_STEP:    angle_step_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Beam angle wraps modulo one turn; the table index is its top bits.
    assign angle     = angle_start_reg + ANGLE_W'(angle_step_reg * beam_index);
    assign cos_angle = angle + ANGLE_W'(QUARTER_TURN);

    assign beam_ok = (beam_range > range_floor_reg) && (beam_range < range_ceiling_reg)
                     && (int'(beam_index) < MAX_BEAMS);

    always_comb
    begin
        cmd.rng          = beam_range;
        cmd.sin_idx      = angle[ANGLE_W-1 -: SINE_W];
        cmd.cos_idx      = cos_angle[ANGLE_W-1 -: SINE_W];
        cmd.cell_in_grid = (int'(cell_row) < GRID_SIDE) && (int'(cell_col) < GRID_SIDE);
        cmd.cell_addr    = ADDR_W'(cell_row) * ADDR_W'(GRID_SIDE) + ADDR_W'(cell_col);
        unique case (opcode)
            OP_CLEAR: cmd.kind = CMD_CLEAR;
            OP_TRACE: cmd.kind = beam_ok ? CMD_TRACE : CMD_NONE;
            OP_READ:  cmd.kind = CMD_READ;
            default:  cmd.kind = CMD_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/lsor_queue.sv -----
// Short request queue between the front end and the back end.
// Depends on lsor_pkg for the request type and depth.
`default_nettype none

module lsor_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire lsor_pkg::cmd_t push_cmd,
    output logic               full,
    output lsor_pkg::q_head_t  head,
    input  wire logic          pop
);
    import lsor_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full       = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ----- sv/lsor_back.sv -----
// Back end: grid memory, sine table, ray stepping sequencer and result register.
// Depends on lsor_pkg; takes requests from lsor_queue.
`default_nettype none

module lsor_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lsor_pkg::q_head_t               head,
    output logic                                 pop,
    output logic                                 init_busy,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [lsor_pkg::VALUE_W-1:0]         cell_value,
    output logic                                 beam_used,
    output logic [lsor_pkg::COUNT_W-1:0]         cells_marked
);
    import lsor_pkg::*;

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CLEAR = 6'b000100,
        S_TRACE = 6'b001000,
        S_DRAIN = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    function automatic logic [VALUE_W-1:0] cell_to_value(cell_code_t code);
        logic [VALUE_W-1:0] v;
        case (code)
            CELL_FREE: v = VAL_FREE;
            CELL_OCC:  v = VAL_OCC;
            default:   v = VAL_UNKNOWN;
        endcase
        return v;
    endfunction

    cell_code_t grid_mem [GRID_CELLS];

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    cmd_kind_t           kind_reg, kind_next;
    logic                in_grid_reg, in_grid_next;
    logic [RANGE_W-1:0]  rng_reg, rng_next;
    logic                first_reg, first_next;
    logic                v1_reg, v1_next;
    cell_code_t          code1_reg, code1_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]  cell_value_reg, cell_value_next;
    logic                beam_used_reg, beam_used_next;
    logic [COUNT_W-1:0]  cells_marked_reg, cells_marked_next;

    logic signed [PROD_W-1:0] prod_s_reg;
    logic signed [PROD_W-1:0] prod_c_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [TRIG_W-1:0] cos_reg;
    cell_code_t               rd_data_reg;

    logic rom_en;
    logic rd_en;

    // Second stage of the ray: floor to a cell, offset to the center, bounds.
    logic signed [PROD_W-FRAC_SHIFT-1:0] row_q;
    logic signed [PROD_W-FRAC_SHIFT-1:0] col_q;
    logic signed [COORD_W-1:0]           row_c;
    logic signed [COORD_W-1:0]           col_c;
    logic                                wr_hit;
    logic [ADDR_W-1:0]                   wr_addr;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    cell_code_t        mem_wdata;

    assign row_q = prod_s_reg[PROD_W-1:FRAC_SHIFT];
    assign col_q = prod_c_reg[PROD_W-1:FRAC_SHIFT];
    assign row_c = COORD_W'(row_q) + COORD_W'(GRID_SIDE / 2);
    assign col_c = COORD_W'(col_q) + COORD_W'(GRID_SIDE / 2);

    assign wr_hit = v1_reg
                    && (row_c >= 0) && (row_c < COORD_W'(GRID_SIDE))
                    && (col_c >= 0) && (col_c < COORD_W'(GRID_SIDE));
    assign wr_addr = ADDR_W'(unsigned'(row_c)) * ADDR_W'(GRID_SIDE)
                     + ADDR_W'(unsigned'(col_c));

    always_comb
    begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        kind_next         = kind_reg;
        in_grid_next      = in_grid_reg;
        rng_next          = rng_reg;
        first_next        = first_reg;
        v1_next           = 1'b0;
        code1_next        = code1_reg;
        count_next        = wr_hit ? count_reg + 1'b1 : count_reg;
        out_valid_next    = out_valid_reg && out_stall;
        cell_value_next   = cell_value_reg;
        beam_used_next    = beam_used_reg;
        cells_marked_next = cells_marked_reg;
        pop               = 1'b0;
        rom_en            = 1'b0;
        rd_en             = 1'b0;

        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(GRID_CELLS - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = (state_reg == S_INIT) ? S_IDLE : S_DONE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop          = 1'b1;
                    kind_next    = head.cmd.kind;
                    in_grid_next = head.cmd.cell_in_grid;
                    rng_next     = head.cmd.rng;
                    first_next   = 1'b1;
                    count_next   = '0;
                    unique case (head.cmd.kind)
                        CMD_CLEAR: state_next = S_CLEAR;
                        CMD_TRACE:
                        begin
                            rom_en     = 1'b1;
                            state_next = S_TRACE;
                        end
                        CMD_READ:
                        begin
                            rd_en      = 1'b1;
                            state_next = S_DONE;
                        end
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_TRACE:
            begin
                // The hit cell goes first as occupied, every cell nearer in as free.
                v1_next    = 1'b1;
                code1_next = first_reg ? CELL_OCC : CELL_FREE;
                first_next = 1'b0;
                if (rng_reg > RANGE_W'(CELL_STEP))
                begin
                    rng_next = rng_reg - RANGE_W'(CELL_STEP);
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    cell_value_next   = '0;
                    beam_used_next    = 1'b0;
                    cells_marked_next = '0;
                    case (kind_reg)
                        CMD_READ:
                        begin
                            cell_value_next = in_grid_reg ? cell_to_value(rd_data_reg)
                                                          : VAL_UNKNOWN;
                        end
                        CMD_TRACE:
                        begin
                            beam_used_next    = 1'b1;
                            cells_marked_next = count_reg;
                        end
                        default: ;
                    endcase
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == S_INIT || state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_addr  = clr_cnt_reg;
            mem_wdata = CELL_UNKNOWN;
        end
        else
        begin
            mem_we    = wr_hit;
            mem_addr  = wr_addr;
            mem_wdata = code1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            clr_cnt_reg   <= '0;
            kind_reg      <= CMD_NONE;
            first_reg     <= 1'b0;
            v1_reg        <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            kind_reg      <= kind_next;
            first_reg     <= first_next;
            v1_reg        <= v1_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_grid_reg      <= in_grid_next;
        rng_reg          <= rng_next;
        code1_reg        <= code1_next;
        cell_value_reg   <= cell_value_next;
        beam_used_reg    <= beam_used_next;
        cells_marked_reg <= cells_marked_next;
        prod_s_reg       <= $signed({1'b0, rng_reg}) * sin_reg;
        prod_c_reg       <= $signed({1'b0, rng_reg}) * cos_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rom_en)
        begin
            sin_reg <= SINE_TAB[head.cmd.sin_idx];
            cos_reg <= SINE_TAB[head.cmd.cos_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_addr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= grid_mem[head.cmd.cell_addr];
        end
    end

    assign init_busy    = (state_reg == S_INIT);
    assign out_valid    = out_valid_reg;
    assign cell_value   = cell_value_reg;
    assign beam_used    = beam_used_reg;
    assign cells_marked = cells_marked_reg;

endmodule

`default_nettype wire

// ----- sv/laser_scan_occupancy_raycast.sv -----
// Top level of the occupancy grid ray caster: front end, request queue, back end.
// Depends on lsor_pkg, lsor_front, lsor_queue and lsor_back.
`default_nettype none

// The block keeps a 128 x 128 occupancy grid in one memory of 2-bit cells, with
// one write port and one registered read port, and the sensor at the center
// cell. Every request returns exactly one result. A clear request rewrites the
// grid one cell per cycle. A trace request looks up sine and cosine, then
// writes one cell per cycle along the ray. For a read request, the registered
// read of the memory happens in the cycle that takes the request from the
// queue. After reset the block first runs a clearing pass over the grid, during
// which in_stall stays high; configuration writes are taken at any time. The
// front end classifies each request and computes its beam angle at the moment
// it is accepted, and a two-entry queue lets new requests come in while the
// back end is busy or while a finished result still waits in the output register.
// Configuration registers must only be written while no request is in flight.

module laser_scan_occupancy_raycast (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write_en,
    input  wire logic [lsor_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lsor_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [lsor_pkg::OPCODE_W-1:0]     opcode,
    input  wire logic [lsor_pkg::INDEX_W-1:0]      beam_index,
    input  wire logic [lsor_pkg::RANGE_W-1:0]      beam_range,
    input  wire logic [lsor_pkg::ROWCOL_W-1:0]     cell_row,
    input  wire logic [lsor_pkg::ROWCOL_W-1:0]     cell_col,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [lsor_pkg::VALUE_W-1:0]           cell_value,
    output logic                                   beam_used,
    output logic [lsor_pkg::COUNT_W-1:0]           cells_marked
);
    import lsor_pkg::*;

    cmd_t    front_cmd;
    q_head_t q_head;
    logic    q_full;
    logic    q_pop;
    logic    init_busy;
    logic    push;

    // Requests are refused while the queue is full or the grid is still being
    // cleared after reset.
    assign in_stall = q_full || init_busy;
    assign push     = in_valid && !in_stall;

    lsor_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .opcode       (opcode),
        .beam_index   (beam_index),
        .beam_range   (beam_range),
        .cell_row     (cell_row),
        .cell_col     (cell_col),
        .cmd          (front_cmd)
    );

    lsor_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .head     (q_head),
        .pop      (q_pop)
    );

    lsor_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .pop          (q_pop),
        .init_busy    (init_busy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cell_value   (cell_value),
        .beam_used    (beam_used),
        .cells_marked (cells_marked)
    );

endmodule

`default_nettype wire
